// ===== sv/skt_pkg.sv =====
package skt_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_READ   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // Operation held for the whole of its compare and update cycles.
  typedef struct packed {
    action_t                 action;
    logic [31:0]             key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [5:0]              pos;
  } cmd_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic full;
    logic found;
  } ctl_t;

  // Compare results a cell holds between its compare and update cycles.
  typedef struct packed {
    logic lt;
    logic eq;
    logic sel;
  } flag_t;

endpackage

// ===== sv/skt_cell.sv =====
module skt_cell (
  input  logic                          clk,
  input  skt_pkg::cmd_t                 cmd,
  input  skt_pkg::ctl_t                 ctl,
  input  logic [skt_pkg::IDX_W-1:0]     idx,
  input  logic [skt_pkg::CNT_W-1:0]     fill,
  input  logic                          left_lt,
  input  logic [31:0]                   left_key,
  input  logic [skt_pkg::PAYLOAD_BITS-1:0] left_payload,
  input  logic [31:0]                   right_key,
  input  logic [skt_pkg::PAYLOAD_BITS-1:0] right_payload,
  output logic [31:0]                   key,
  output logic [skt_pkg::PAYLOAD_BITS-1:0] payload,
  output skt_pkg::flag_t                flags
);
  import skt_pkg::*;

  logic  held;
  flag_t flags_next;

  // A cell holds an entry when its position lies below the fill count.
  assign held = CNT_W'(idx) < fill;

  always_comb begin
    flags_next.lt  = held && (key < cmd.key);
    flags_next.eq  = held && (key == cmd.key);
    flags_next.sel = held && (32'(cmd.pos) == 32'(idx));
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      flags <= flags_next;
    end
    if (ctl.upd_en) begin
      case (cmd.action)
        ACT_INSERT: begin
          // Cells at or after the insertion point take the new entry or
          // the entry of their left neighbour.
          if (!ctl.full && !flags.lt) begin
            if (left_lt) begin
              key     <= cmd.key;
              payload <= cmd.payload;
            end else begin
              key     <= left_key;
              payload <= left_payload;
            end
          end
        end
        ACT_REMOVE: begin
          if (ctl.found && !flags.lt) begin
            key     <= right_key;
            payload <= right_payload;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/sorted_key_table_unit.sv =====
// Sorted key table: a row of TABLE_DEPTH cells holds up to that many entries,
// each a 32-bit key and a data word, in ascending key order. Every operation
// word on the slave side carries the action in s_tuser and the key, data word
// and position in s_tdata; it returns exactly one result word on the master
// side. Each operation passes through a compare state and then an update
// state: in the first every cell compares its key with the operation key
// and stores the outcome, in the second every cell shifts, loads or keeps
// its entry using its own and its neighbours' outcomes, and the result word
// is registered. A new word is taken in the update cycle of the previous
// one, so the next word is not taken before this compare-then-update
// sequence of the cell row reaches its update cycle. The result register
// may hold a word while the next operation is compared; the update cycle
// waits only while an earlier result is still not taken.
// Insertion of an equal key goes before existing equal keys, and remove and
// find act on the first entry with a matching key. Entries need no clearing
// after reset: only positions below the fill count are ever used.
module sorted_key_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0 up: entity_key[31:0], payload_in[31:0],
  // position[5:0], zero fill to 72 bits.
  input  logic [71:0] s_tdata,
  // s_tuser: action[2:0].
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0 up: key_out[31:0], payload_out[31:0],
  // where_found[5:0], entries_held[6:0], zero fill to 80 bits.
  output logic [79:0] m_tdata,
  // m_tuser: status[1:0].
  output logic [1:0]  m_tuser
);
  import skt_pkg::*;

  state_t state, state_next;
  cmd_t   cmd;
  ctl_t   ctl;
  logic   s_accept;
  logic   can_commit;

  logic [CNT_W-1:0] fill, fill_next;

  logic [31:0]             cell_key     [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [TABLE_DEPTH];
  flag_t                   cell_flags   [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] ins_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;

  status_t                 res_status;
  logic [31:0]             res_key;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic [IDX_W-1:0]        res_where;

  logic [31:0]             sel_key;
  logic [PAYLOAD_BITS-1:0] sel_payload;

  status_t     out_status;
  logic [31:0] out_key;
  logic [31:0] out_payload;
  logic [5:0]  out_where;
  logic [6:0]  out_count;

  // One-hot to binary position of a flag vector.
  function automatic logic [IDX_W-1:0] encode(input logic [TABLE_DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (v[j]) begin
        r = r | IDX_W'(j);
      end
    end
    return r;
  endfunction

  assign s_accept   = s_tvalid && s_tready;
  assign can_commit = !m_tvalid || m_tready;

  // Sequencer: compare cycle, then update cycle that also takes the next word.
  // The full and found indications are broadcast to the cells from here too.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctl.cmp_en = 1'b0;
    ctl.upd_en = 1'b0;
    ctl.full   = (fill == CNT_W'(TABLE_DEPTH));
    ctl.found  = |hit_vec;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctl.cmp_en = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (can_commit) begin
          ctl.upd_en = 1'b1;
          s_tready   = 1'b1;
          state_next = s_tvalid ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      cmd.action  <= action_t'(s_tuser);
      cmd.key     <= s_tdata[31:0];
      cmd.payload <= PAYLOAD_BITS'(s_tdata[63:32]);
      cmd.pos     <= s_tdata[69:64];
    end
  end

  // The row of cells. Cell zero sees a left neighbour whose key is below
  // every key; the last cell's right neighbour is never taken for a held
  // entry, so it is fed its own word.
  generate
    for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_chain
      logic                    l_lt;
      logic [31:0]             l_key;
      logic [PAYLOAD_BITS-1:0] l_payload;
      logic [31:0]             r_key;
      logic [PAYLOAD_BITS-1:0] r_payload;

      if (j == 0) begin : g_first
        assign l_lt      = 1'b1;
        assign l_key     = cell_key[j];
        assign l_payload = cell_payload[j];
      end else begin : g_inner_l
        assign l_lt      = cell_flags[j-1].lt;
        assign l_key     = cell_key[j-1];
        assign l_payload = cell_payload[j-1];
      end

      if (j == TABLE_DEPTH - 1) begin : g_last
        assign r_key     = cell_key[j];
        assign r_payload = cell_payload[j];
      end else begin : g_inner_r
        assign r_key     = cell_key[j+1];
        assign r_payload = cell_payload[j+1];
      end

      // Insertion point: first cell whose key is not below the new key.
      assign ins_vec[j] = !cell_flags[j].lt && l_lt;

      // Equal keys sit together, so the first match has no match on its left.
      if (j == 0) begin : g_hit_first
        always_comb begin
          if (cmd.action == ACT_READ) begin
            hit_vec[j] = cell_flags[j].sel;
          end else begin
            hit_vec[j] = cell_flags[j].eq;
          end
        end
      end else begin : g_hit_inner
        always_comb begin
          if (cmd.action == ACT_READ) begin
            hit_vec[j] = cell_flags[j].sel;
          end else begin
            hit_vec[j] = cell_flags[j].eq && !cell_flags[j-1].eq;
          end
        end
      end

      skt_cell u_cell (
        .clk           (clk),
        .cmd           (cmd),
        .ctl           (ctl),
        .idx           (IDX_W'(j)),
        .fill          (fill),
        .left_lt       (l_lt),
        .left_key      (l_key),
        .left_payload  (l_payload),
        .right_key     (r_key),
        .right_payload (r_payload),
        .key           (cell_key[j]),
        .payload       (cell_payload[j]),
        .flags         (cell_flags[j])
      );
    end
  endgenerate

  // The hit vector is one-hot or empty, so an AND-OR picks the entry.
  always_comb begin
    sel_key     = '0;
    sel_payload = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (hit_vec[j]) begin
        sel_key     = sel_key | cell_key[j];
        sel_payload = sel_payload | cell_payload[j];
      end
    end
  end

  always_comb begin
    res_status  = ST_OK;
    res_key     = '0;
    res_payload = '0;
    res_where   = '0;
    fill_next   = fill;
    case (cmd.action)
      ACT_INSERT: begin
        if (ctl.full) begin
          res_status = ST_FULL;
        end else begin
          res_key     = cmd.key;
          res_payload = cmd.payload;
          res_where   = encode(ins_vec);
          fill_next   = fill + CNT_W'(1);
        end
      end
      ACT_REMOVE, ACT_FIND: begin
        if (!ctl.found) begin
          res_status = ST_MISSING;
        end else begin
          res_key     = sel_key;
          res_payload = sel_payload;
          res_where   = encode(hit_vec);
          if (cmd.action == ACT_REMOVE) begin
            fill_next = fill - CNT_W'(1);
          end
        end
      end
      ACT_READ: begin
        if (!ctl.found) begin
          res_status = ST_RANGE;
        end else begin
          res_key     = sel_key;
          res_payload = sel_payload;
          res_where   = encode(hit_vec);
        end
      end
      ACT_CLEAR: begin
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.upd_en) begin
        fill     <= fill_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_en) begin
      out_status  <= res_status;
      out_key     <= res_key;
      out_payload <= 32'(res_payload);
      out_where   <= 6'(res_where);
      out_count   <= 7'(fill_next);
    end
  end

  assign m_tdata = {3'b000, out_count, out_where, out_payload, out_key};
  assign m_tuser = out_status;

endmodule

// ===== sv/skt_checker.sv =====
module skt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import skt_pkg::*;

  // A result word waiting to be taken stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[76:70] <= 7'(TABLE_DEPTH))
    else $error("entries_held beyond table depth");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[76:70] == 7'(TABLE_DEPTH))
    else $error("full status with a table that is not full");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_MISSING || m_tuser == ST_RANGE || m_tuser == ST_FULL)
      |-> m_tdata[69:0] == 70'd0)
    else $error("refused operation reports an entry");

  a_where: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_OK |-> 7'(m_tdata[69:64]) <= m_tdata[76:70])
    else $error("position beyond entries held");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== bench/sorted_key_table_checker.sv =====
module sorted_key_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // s_tdata, from bit 0 up: entity_key[31:0], payload_in[31:0], position[5:0].
  input  logic [71:0] s_tdata,
  // s_tuser: action[2:0].
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0 up: key_out[31:0], payload_out[31:0], where_found[5:0],
  // entries_held[6:0].
  input  logic [79:0] m_tdata,
  // m_tuser: status[1:0].
  input  logic [1:0]  m_tuser,
  output int unsigned mismatches,
  output int unsigned replies_owed,
  output int unsigned replies_checked,
  output int unsigned full_refusals,
  output int unsigned peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] key;
    logic [31:0] data;
    logic [5:0]  where;
    logic [6:0]  held;
  } reply_t;

  // Shadow copy of the table, kept in ascending key order.
  logic [31:0]             shadow_keys [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] shadow_data [TABLE_DEPTH];
  int unsigned             shadow_fill;

  reply_t predicted_replies [$];

  // Applies one operation word to the shadow table and returns the reply it should give.
  function automatic reply_t table_operation(logic [2:0] act, logic [31:0] key,
                                             logic [31:0] data, logic [5:0] pos);
    reply_t      r;
    int unsigned slot;
    int unsigned j;
    r        = '0;
    r.status = ST_OK;
    if (act == ACT_INSERT) begin
      if (shadow_fill >= TABLE_DEPTH) begin
        r.status = ST_FULL;
        full_refusals++;
      end else begin
        // An equal key goes in front of the entries already holding it.
        slot = 0;
        while (slot < shadow_fill && shadow_keys[slot] < key) slot++;
        for (j = shadow_fill; j > slot; j--) begin
          shadow_keys[j] = shadow_keys[j-1];
          shadow_data[j] = shadow_data[j-1];
        end
        shadow_keys[slot] = key;
        shadow_data[slot] = data[PAYLOAD_BITS-1:0];
        shadow_fill++;
        r.key   = key;
        r.data  = 32'(shadow_data[slot]);
        r.where = slot[5:0];
      end
    end else if (act == ACT_REMOVE || act == ACT_FIND) begin
      slot = 0;
      while (slot < shadow_fill && shadow_keys[slot] != key) slot++;
      if (slot == shadow_fill) begin
        r.status = ST_MISSING;
      end else begin
        r.key   = shadow_keys[slot];
        r.data  = 32'(shadow_data[slot]);
        r.where = slot[5:0];
        if (act == ACT_REMOVE) begin
          for (j = slot; j + 1 < shadow_fill; j++) begin
            shadow_keys[j] = shadow_keys[j+1];
            shadow_data[j] = shadow_data[j+1];
          end
          shadow_fill--;
        end
      end
    end else if (act == ACT_READ) begin
      if (pos >= shadow_fill) begin
        r.status = ST_RANGE;
      end else begin
        r.key   = shadow_keys[pos];
        r.data  = 32'(shadow_data[pos]);
        r.where = pos;
      end
    end else if (act == ACT_CLEAR) begin
      shadow_fill = 0;
    end
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.held = shadow_fill[6:0];
    return r;
  endfunction

  // Results are handled before new words: a result leaving at this edge
  // always belongs to a word taken at an earlier edge.
  always @(posedge clk) begin : watch_channels
    reply_t seen;
    reply_t want;
    if (rst) begin
      shadow_fill     = 0;
      mismatches      = 0;
      replies_owed    = 0;
      replies_checked = 0;
      full_refusals   = 0;
      peak_fill       = 0;
      predicted_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.status = status_t'(m_tuser);
        seen.key    = m_tdata[31:0];
        seen.data   = m_tdata[63:32];
        seen.where  = m_tdata[69:64];
        seen.held   = m_tdata[76:70];
        if (predicted_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word: status %0d key %h data %h pos %0d held %0d",
                     seen.status, seen.key, seen.data, seen.where, seen.held);
        end else begin
          want = predicted_replies.pop_front();
          replies_checked++;
          if (seen.status !== want.status || seen.key !== want.key ||
              seen.data !== want.data || seen.where !== want.where ||
              seen.held !== want.held) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: expected status %0d key %h data %h pos %0d held %0d,",
                       want.status, want.key, want.data, want.where, want.held,
                       " got status %0d key %h data %h pos %0d held %0d",
                       seen.status, seen.key, seen.data, seen.where, seen.held);
          end
        end
      end
      if (s_tvalid && s_tready)
        predicted_replies.push_back(table_operation(s_tuser, s_tdata[31:0],
                                                    s_tdata[63:32], s_tdata[69:64]));
      replies_owed = predicted_replies.size();
    end
  end

endmodule

// ===== bench/sorted_key_table_unit_test.sv =====
module sorted_key_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  // The run ends here whatever happens.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_WORDS  = 2000;
  localparam int unsigned SEGMENT_WORDS = 100;
  // The receiver stops taking results for this many cycles once it has taken
  // HOLD_AFTER words, so that the block backs up and drops s_tready.
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned HOLD_AFTER    = 300;

  // Action codes the block has no use for; it must answer them and change nothing.
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  // The random part runs in segments, each with its own mix of operations.
  // The first segment only inserts, which fills the table and then hits the
  // full case repeatedly.
  typedef enum int {
    MIX_FILL,
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;

  int unsigned mismatches;
  int unsigned replies_owed;
  int unsigned replies_checked;
  int unsigned full_refusals;
  int unsigned peak_fill;
  int unsigned cycles = 0;

  // When set, the sender offers words back to back for the current segment.
  bit sender_quiet = 1'b0;

  // Recently inserted keys, so that finds and removes mostly hit something.
  logic [31:0] key_pool [16];
  logic [31:0] key_edges [4];

  sorted_key_table_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sorted_key_table_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .mismatches      (mismatches),
    .replies_owed    (replies_owed),
    .replies_checked (replies_checked),
    .full_refusals   (full_refusals),
    .peak_fill       (peak_fill)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Guards against a block that stops answering.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d result words outstanding",
               replies_owed);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one operation word and returns at the falling edge after it has
  // been taken. A word that follows with no gap keeps s_tvalid high, so the
  // valid is never lowered and raised within one time step.
  task automatic send_word(input logic [2:0] act, input logic [31:0] key,
                           input logic [31:0] data, input logic [5:0] pos);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, pos, data, key};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
    if (act == ACT_INSERT) key_pool[$urandom_range(0, 15)] = key;
  endtask

  // Keys lean towards a small range and recent inserts, so that equal keys
  // and hits are common, with full-width random keys and the extremes mixed in.
  function automatic logic [31:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return key_pool[$urandom_range(0, 15)];
    if (roll < 65) return 32'($urandom_range(0, 15));
    if (roll < 75) return key_edges[$urandom_range(0, 3)];
    return 32'($urandom);
  endfunction

  // Result side: a random wait before each word, some stretches with none,
  // and one long hold-off counted here in cycles.
  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    bit          quiet;
    taken = 0;
    quiet = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (taken == HOLD_AFTER) gap = LONG_HOLD;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    mix_t        mix;
    logic [2:0]  act;
    logic [31:0] key;
    int unsigned roll;
    int unsigned segment;
    int unsigned n;
    int unsigned insert_cut;
    int unsigned remove_cut;
    int unsigned find_cut;
    key_edges[0] = 32'h0000_0000;
    key_edges[1] = 32'hFFFF_FFFF;
    key_edges[2] = 32'h8000_0000;
    key_edges[3] = 32'h7FFF_FFFF;
    for (n = 0; n < 16; n++) key_pool[n] = 32'(n);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. On an empty table every lookup must fail.
    send_word(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(ACT_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 6'd63);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
    // Extreme keys and data words; the second zero key must land in front
    // of the first one.
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_word(ACT_INSERT, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(ACT_INSERT, 32'h8000_0000, 32'hA5A5_5A5A, 6'd21);
    send_word(ACT_INSERT, 32'h0000_0000, 32'h1234_5678, 6'd42);
    // Reads at both ends of the filled part and just past it.
    send_word(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd1);
    send_word(ACT_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd3);
    send_word(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd4);
    send_word(ACT_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    // Find and remove act on the first of the equal keys.
    send_word(ACT_FIND,   32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
    send_word(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(ACT_FIND,   32'h8000_0000, 32'h0000_0000, 6'd0);
    send_word(ACT_FIND,   32'h0000_0005, 32'h0000_0000, 6'd0);
    // Unused codes must leave the table alone.
    send_word(ACT_UNUSED_FIRST, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(3'(ACT_UNUSED_FIRST + 1), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_word(ACT_UNUSED_LAST,  32'h8000_0000, 32'hA5A5_5A5A, 6'd1);
    send_word(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd1);
    // Clearing empties the table.
    send_word(ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_word(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(ACT_FIND,   32'h0000_0000, 32'h0000_0000, 6'd0);

    // Random part, segment by segment.
    for (segment = 0; segment < RANDOM_WORDS / SEGMENT_WORDS; segment++) begin
      mix = (segment == 0) ? MIX_FILL : mix_t'($urandom_range(MIX_GROW, MIX_EVEN));
      sender_quiet = ($urandom_range(0, 3) == 0);
      case (mix)
        MIX_GROW: begin
          insert_cut = 60; remove_cut = 70; find_cut = 85;
        end
        MIX_SHRINK: begin
          insert_cut = 30; remove_cut = 65; find_cut = 80;
        end
        default: begin
          insert_cut = 45; remove_cut = 65; find_cut = 82;
        end
      endcase
      for (n = 0; n < SEGMENT_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (mix == MIX_FILL)        act = ACT_INSERT;
        else if (roll < 2)          act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        else if (roll < 3)          act = ACT_CLEAR;
        else if (roll < insert_cut) act = ACT_INSERT;
        else if (roll < remove_cut) act = ACT_REMOVE;
        else if (roll < find_cut)   act = ACT_FIND;
        else                        act = ACT_READ;
        // Lookups get a further push towards keys that were recently stored.
        if ((act == ACT_REMOVE || act == ACT_FIND) && $urandom_range(0, 1) == 0)
          key = key_pool[$urandom_range(0, 15)];
        else
          key = pick_key();
        send_word(act, key, 32'($urandom), 6'($urandom_range(0, 63)));
      end
    end
    s_tvalid <= 1'b0;

    wait (replies_owed == 0);
    repeat (10) @(posedge clk);
    $display("Checked %0d result words over %0d operation words, %0d of them refused inserts",
             replies_checked, RANDOM_WORDS + 24, full_refusals);
    $display("into a full table; the table peaked at %0d of %0d entries.",
             peak_fill, TABLE_DEPTH);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
